@@ src/rbdfd_pkg.sv @@
// rbdfd_pkg: shared constants, register codes and payload types for the
// box downscale and frame difference block
// no dependencies
package rbdfd_pkg;

    localparam int CFG_W           = 11;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int BLOCK_SIZE_DEF  = 4;
    localparam int MAX_HEIGHT      = 1024;
    localparam int ROW_W           = 10;
    localparam int H_W             = 11;
    localparam int DIFF_W          = 40;
    localparam int SQ_W            = 16;
    localparam int QD              = 8;
    localparam int QPW             = $clog2(QD);
    localparam int QCW             = $clog2(QD + 1);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd720;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd576;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_THUMB = 1'b0;
    localparam logic KIND_DIFF  = 1'b1;

    typedef struct packed {
        logic [7:0] cap_first_byte;
        logic [7:0] cap_middle_byte;
        logic [7:0] cap_third_byte;
        logic [7:0] ref_first_byte;
        logic [7:0] ref_middle_byte;
        logic [7:0] ref_third_byte;
    } t_in;

    typedef struct packed {
        logic              result_kind;
        logic [7:0]        thumb_first;
        logic [7:0]        thumb_middle;
        logic [7:0]        thumb_third;
        logic [DIFF_W-1:0] frame_difference;
        logic              last_of_run;
    } t_out;

    typedef struct packed {
        logic valid;
        logic inrange;
        logic done;
        logic frame_end;
        logic fwd_hit;
        logic after_clr;
    } t_flags;

    typedef struct packed {
        logic              has_thumb;
        logic              has_diff;
        logic [7:0]        thumb_first;
        logic [7:0]        thumb_middle;
        logic [7:0]        thumb_third;
        logic [DIFF_W-1:0] diff;
    } t_entry;

endpackage

@@ src/rbdfd_ctrl.sv @@
// rbdfd_ctrl: frame size registers, raster and block position counters,
// stage flags shared by the lanes and the merge stage
// depends on rbdfd_pkg
module rbdfd_ctrl #(
    parameter int MAX_WIDTH  = rbdfd_pkg::MAX_WIDTH_DEF,
    parameter int BLOCK_SIZE = rbdfd_pkg::BLOCK_SIZE_DEF,
    localparam int NB  = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
    localparam int BCW = $clog2(NB)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [rbdfd_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                        i_acc,
    output logic [BCW-1:0]              o_cur_bc,
    output rbdfd_pkg::t_flags           o_s1,
    output logic [BCW-1:0]              o_s1_bc,
    output rbdfd_pkg::t_flags           o_s2
);

    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int CIBW = $clog2(BLOCK_SIZE);
    localparam int EWA  = $clog2(MAX_WIDTH + BLOCK_SIZE + 1);
    localparam int EW   = (EWA > rbdfd_pkg::CFG_W) ? EWA : rbdfd_pkg::CFG_W;
    localparam int HW   = rbdfd_pkg::H_W;

    logic [rbdfd_pkg::CFG_W-1:0] r_width, r_height;
    logic [COLW-1:0]             r_col;
    logic [rbdfd_pkg::ROW_W-1:0] r_row;
    logic [CIBW-1:0]             r_cib, r_rib;
    logic [BCW-1:0]              r_bc;
    logic [EW-1:0]               r_bend;
    logic [HW-1:0]               r_rend;
    rbdfd_pkg::t_flags           r_s1, r_s2;
    logic [BCW-1:0]              r_s1_bc;

    logic [EW-1:0] eff_w;
    logic [HW-1:0] eff_h;
    logic          line_end, frame_end, inrange, done;

    always_comb begin
        if (r_width == '0) begin
            eff_w = EW'(1);
        end else if (EW'(r_width) > EW'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(r_width);
        end
        if (r_height == '0) begin
            eff_h = HW'(1);
        end else if (HW'(r_height) > HW'(rbdfd_pkg::MAX_HEIGHT)) begin
            eff_h = HW'(rbdfd_pkg::MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_height);
        end
    end

    assign line_end  = (EW'(r_col) + EW'(1)) >= eff_w;
    assign frame_end = line_end && ((HW'(r_row) + HW'(1)) >= eff_h);
    assign inrange   = (r_bend <= eff_w) && (r_rend <= eff_h);
    assign done      = (r_cib == CIBW'(BLOCK_SIZE - 1)) && (r_rib == CIBW'(BLOCK_SIZE - 1));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rbdfd_pkg::WIDTH_RESET;
            r_height <= rbdfd_pkg::HEIGHT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                rbdfd_pkg::REG_FRAME_WIDTH:  r_width  <= i_cfg_wr_data;
                rbdfd_pkg::REG_FRAME_HEIGHT: r_height <= i_cfg_wr_data;
            endcase
        end
    end

    // raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
            r_bc   <= '0;
            r_bend <= EW'(BLOCK_SIZE);
            r_rend <= HW'(BLOCK_SIZE);
        end else if (i_acc) begin
            if (frame_end) begin
                r_col  <= '0;
                r_row  <= '0;
                r_cib  <= '0;
                r_rib  <= '0;
                r_bc   <= '0;
                r_bend <= EW'(BLOCK_SIZE);
                r_rend <= HW'(BLOCK_SIZE);
            end else if (line_end) begin
                r_col  <= '0;
                r_cib  <= '0;
                r_bc   <= '0;
                r_bend <= EW'(BLOCK_SIZE);
                r_row  <= r_row + 1'b1;
                if (r_rib == CIBW'(BLOCK_SIZE - 1)) begin
                    r_rib  <= '0;
                    r_rend <= r_rend + HW'(BLOCK_SIZE);
                end else begin
                    r_rib <= r_rib + 1'b1;
                end
            end else begin
                r_col <= r_col + 1'b1;
                if (r_cib == CIBW'(BLOCK_SIZE - 1)) begin
                    r_cib  <= '0;
                    r_bc   <= r_bc + 1'b1;
                    r_bend <= r_bend + EW'(BLOCK_SIZE);
                end else begin
                    r_cib <= r_cib + 1'b1;
                end
            end
        end
    end

    // stage flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= '0;
            r_s2    <= '0;
            r_s1_bc <= '0;
        end else begin
            r_s1.valid     <= i_acc;
            r_s1.inrange   <= inrange;
            r_s1.done      <= done;
            r_s1.frame_end <= frame_end;
            r_s1.fwd_hit   <= r_s1.valid && r_s1.inrange && (r_s1_bc == r_bc);
            r_s1.after_clr <= r_s1.valid && r_s1.frame_end;
            r_s1_bc        <= r_bc;
            r_s2           <= r_s1;
        end
    end

    assign o_cur_bc = r_bc;
    assign o_s1     = r_s1;
    assign o_s1_bc  = r_s1_bc;
    assign o_s2     = r_s2;

endmodule

@@ src/rbdfd_lane.sv @@
// rbdfd_lane: one color channel: band sum memory with read-modify-write,
// block average and squared difference against the reference byte
// depends on rbdfd_pkg
module rbdfd_lane #(
    parameter int MAX_WIDTH  = rbdfd_pkg::MAX_WIDTH_DEF,
    parameter int BLOCK_SIZE = rbdfd_pkg::BLOCK_SIZE_DEF,
    localparam int NB  = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE,
    localparam int BCW = $clog2(NB)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [BCW-1:0]             i_cur_bc,
    input  rbdfd_pkg::t_flags          i_s1,
    input  logic [BCW-1:0]             i_s1_bc,
    input  logic [7:0]                 i_cap,
    input  logic [7:0]                 i_ref,
    output logic [7:0]                 o_thumb,
    output logic [rbdfd_pkg::SQ_W-1:0] o_sq
);

    localparam int AREA  = BLOCK_SIZE * BLOCK_SIZE;
    localparam int SW    = $clog2(AREA * 255 + 1);
    localparam int AW    = $clog2(AREA);
    localparam int K     = SW + AW;
    localparam int RECIP = (2 ** K + AREA - 1) / AREA;
    localparam int PW    = 2 * SW + 1;

    logic [SW-1:0] r_mem [NB];
    logic [NB-1:0] r_vld;
    logic [SW-1:0] r_rd, r_fwd, r_sum2;
    logic          r_rd_vld;
    logic [7:0]    r_cap1, r_ref1;
    logic [rbdfd_pkg::SQ_W-1:0] r_sq2;

    logic [SW-1:0] base, sum, wr;
    logic [7:0]    ad;
    logic [PW-1:0] prod;

    always_comb begin
        if (i_s1.after_clr) begin
            base = '0;
        end else if (i_s1.fwd_hit) begin
            base = r_fwd;
        end else if (r_rd_vld) begin
            base = r_rd;
        end else begin
            base = '0;
        end
    end

    assign sum = base + SW'(r_cap1);
    assign wr  = i_s1.done ? '0 : sum;
    assign ad  = (r_cap1 >= r_ref1) ? (r_cap1 - r_ref1) : (r_ref1 - r_cap1);

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_cur_bc];
        if (i_s1.valid && i_s1.inrange) begin
            r_mem[i_s1_bc] <= wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_cur_bc];
            if (i_s1.valid && i_s1.frame_end) begin
                r_vld <= '0;
            end else if (i_s1.valid && i_s1.inrange) begin
                r_vld[i_s1_bc] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cap1 <= i_cap;
        r_ref1 <= i_ref;
        r_fwd  <= wr;
        r_sum2 <= sum;
        r_sq2  <= 16'(ad) * 16'(ad);
    end

    // sum / AREA by reciprocal, exact over the sum range
    assign prod    = PW'(r_sum2) * PW'(RECIP);
    assign o_thumb = prod[K+7:K];
    assign o_sq    = r_sq2;

endmodule

@@ src/rbdfd_merge.sv @@
// rbdfd_merge: combines the lane results: frame difference total, result
// queue with slot reservation, and the output channel
// depends on rbdfd_pkg
module rbdfd_merge (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_acc,
    input  rbdfd_pkg::t_flags          i_s2,
    input  logic [7:0]                 i_thumb_first,
    input  logic [7:0]                 i_thumb_middle,
    input  logic [7:0]                 i_thumb_third,
    input  logic [rbdfd_pkg::SQ_W-1:0] i_sq_first,
    input  logic [rbdfd_pkg::SQ_W-1:0] i_sq_middle,
    input  logic [rbdfd_pkg::SQ_W-1:0] i_sq_third,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    output rbdfd_pkg::t_out            o_out_data,
    input  logic                       i_out_stall
);

    localparam int DW = rbdfd_pkg::DIFF_W;

    logic [DW-1:0]              r_tot;
    rbdfd_pkg::t_entry          r_q [rbdfd_pkg::QD];
    logic [rbdfd_pkg::QPW-1:0]  r_wp, r_rp;
    logic [rbdfd_pkg::QCW-1:0]  r_cnt, r_used;
    logic                       r_sub;

    logic [rbdfd_pkg::SQ_W+1:0] d;
    logic [DW:0]                n_sum;
    logic [DW-1:0]              n_tot;
    logic                       has_thumb, push, pop, show_thumb;
    rbdfd_pkg::t_entry          ent, head;

    assign d     = 18'(i_sq_first) + 18'(i_sq_middle) + 18'(i_sq_third);
    assign n_sum = {1'b0, r_tot} + (DW + 1)'(d);
    assign n_tot = n_sum[DW] ? {DW{1'b1}} : n_sum[DW-1:0];

    assign has_thumb = i_s2.inrange && i_s2.done;
    assign push      = i_s2.valid && (has_thumb || i_s2.frame_end);

    always_comb begin
        ent              = '0;
        ent.has_thumb    = has_thumb;
        ent.has_diff     = i_s2.frame_end;
        ent.thumb_first  = i_thumb_first;
        ent.thumb_middle = i_thumb_middle;
        ent.thumb_third  = i_thumb_third;
        ent.diff         = n_tot;
    end

    assign head        = r_q[r_rp];
    assign o_out_valid = (r_cnt != '0);
    assign show_thumb  = !r_sub && head.has_thumb;
    assign pop         = o_out_valid && !i_out_stall && !(show_thumb && head.has_diff);
    assign o_in_stall  = (r_used >= rbdfd_pkg::QCW'(rbdfd_pkg::QD));

    always_comb begin
        o_out_data = '0;
        if (show_thumb) begin
            o_out_data.result_kind  = rbdfd_pkg::KIND_THUMB;
            o_out_data.thumb_first  = head.thumb_first;
            o_out_data.thumb_middle = head.thumb_middle;
            o_out_data.thumb_third  = head.thumb_third;
            o_out_data.last_of_run  = !head.has_diff;
        end else begin
            o_out_data.result_kind      = rbdfd_pkg::KIND_DIFF;
            o_out_data.frame_difference = head.diff;
            o_out_data.last_of_run      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot  <= '0;
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_used <= '0;
            r_sub  <= 1'b0;
        end else begin
            if (i_s2.valid) begin
                r_tot <= i_s2.frame_end ? '0 : n_tot;
            end
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                if (pop) begin
                    r_rp  <= r_rp + 1'b1;
                    r_sub <= 1'b0;
                end else begin
                    r_sub <= 1'b1;
                end
            end
            r_cnt  <= r_cnt + rbdfd_pkg::QCW'(push) - rbdfd_pkg::QCW'(pop);
            r_used <= r_used + rbdfd_pkg::QCW'(i_acc)
                      - rbdfd_pkg::QCW'(i_s2.valid && !push) - rbdfd_pkg::QCW'(pop);
        end
    end

    a_cnt_within_resv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_used)
        else $error("queue holds more entries than reserved");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_cnt < rbdfd_pkg::QCW'(rbdfd_pkg::QD)))
        else $error("result pushed into a full queue");

    a_second_is_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_sub) |-> head.has_diff)
        else $error("second result of an entry without a difference total");

endmodule

@@ src/rgb_box_downscale_frame_diff_core.sv @@
// rgb_box_downscale_frame_diff_core: top level, one lane per color channel,
// position control and result merge
// depends on rbdfd_pkg, rbdfd_ctrl, rbdfd_lane, rbdfd_merge
//
// Input channel: one captured pixel plus the matching reference pixel per
// transfer, in raster order, one per clock when not stalled. First and third
// captured bytes are swapped; each channel lane sums BLOCK_SIZE x BLOCK_SIZE
// blocks in a band memory (one entry per block column, read-modify-write with
// forwarding) and emits the block average on the block's bottom-right pixel.
// The frame's last pixel also emits the squared difference total and clears
// the band sums and the position. Partial edge blocks produce nothing.
// Path: results pass the stage 1 and stage 2 registers, then the queue.
// Throughput: one pixel per cycle unless stalled, kept by band forwarding.
// Output channel: a queue of eight entries, each holding the results of one
// pixel (thumbnail first, then difference total). A stalled receiver fills
// the queue; input stall rises once queued plus in-flight pixels reach eight.
// Reset: sizes return to 720 x 576, position and totals to zero, band sums
// read as zero; no clearing pass, input is taken right after reset.
// Configuration: frame_width index 0, frame_height index 1, write when idle.
module rgb_box_downscale_frame_diff_core #(
    parameter int MAX_WIDTH  = rbdfd_pkg::MAX_WIDTH_DEF,
    parameter int BLOCK_SIZE = rbdfd_pkg::BLOCK_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic                        i_cfg_index,
    input  logic [rbdfd_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  logic                        i_in_valid,
    input  rbdfd_pkg::t_in              i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output rbdfd_pkg::t_out             o_out_data,
    input  logic                        i_out_stall
);

    localparam int NB  = (MAX_WIDTH + BLOCK_SIZE - 1) / BLOCK_SIZE;
    localparam int BCW = $clog2(NB);

    logic                       acc;
    logic [BCW-1:0]             cur_bc, s1_bc;
    rbdfd_pkg::t_flags          s1, s2;
    logic [7:0]                 th_first, th_middle, th_third;
    logic [rbdfd_pkg::SQ_W-1:0] sq_first, sq_middle, sq_third;

    assign acc = i_in_valid && !o_in_stall;

    rbdfd_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .BLOCK_SIZE(BLOCK_SIZE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_acc        (acc),
        .o_cur_bc     (cur_bc),
        .o_s1         (s1),
        .o_s1_bc      (s1_bc),
        .o_s2         (s2)
    );

    rbdfd_lane #(
        .MAX_WIDTH (MAX_WIDTH),
        .BLOCK_SIZE(BLOCK_SIZE)
    ) u_lane_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cur_bc(cur_bc),
        .i_s1    (s1),
        .i_s1_bc (s1_bc),
        .i_cap   (i_in_data.cap_third_byte),
        .i_ref   (i_in_data.ref_first_byte),
        .o_thumb (th_first),
        .o_sq    (sq_first)
    );

    rbdfd_lane #(
        .MAX_WIDTH (MAX_WIDTH),
        .BLOCK_SIZE(BLOCK_SIZE)
    ) u_lane_middle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cur_bc(cur_bc),
        .i_s1    (s1),
        .i_s1_bc (s1_bc),
        .i_cap   (i_in_data.cap_middle_byte),
        .i_ref   (i_in_data.ref_middle_byte),
        .o_thumb (th_middle),
        .o_sq    (sq_middle)
    );

    rbdfd_lane #(
        .MAX_WIDTH (MAX_WIDTH),
        .BLOCK_SIZE(BLOCK_SIZE)
    ) u_lane_third (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cur_bc(cur_bc),
        .i_s1    (s1),
        .i_s1_bc (s1_bc),
        .i_cap   (i_in_data.cap_first_byte),
        .i_ref   (i_in_data.ref_third_byte),
        .o_thumb (th_third),
        .o_sq    (sq_third)
    );

    rbdfd_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (acc),
        .i_s2          (s2),
        .i_thumb_first (th_first),
        .i_thumb_middle(th_middle),
        .i_thumb_third (th_third),
        .i_sq_first    (sq_first),
        .i_sq_middle   (sq_middle),
        .i_sq_third    (sq_third),
        .o_in_stall    (o_in_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

endmodule

@@ bench/rgb_box_downscale_frame_diff_core_test.sv @@
// rgb_box_downscale_frame_diff_core_test: self-checking bench for the 4x4 box downscale
// and frame difference core, a table of directed pixels followed by random frames
// depends on rbdfd_pkg and rgb_box_downscale_frame_diff_core
module rgb_box_downscale_frame_diff_core_test;
    import rbdfd_pkg::*;

    localparam int BANDS     = MAX_WIDTH_DEF / BLOCK_SIZE_DEF;
    localparam int AREA      = BLOCK_SIZE_DEF * BLOCK_SIZE_DEF;
    localparam int RAND_ITEMS = 1200;

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_wr_en   = 1'b0;
    logic              i_cfg_index   = REG_FRAME_WIDTH;
    logic [CFG_W-1:0]  i_cfg_wr_data = '0;
    logic              i_in_valid    = 1'b0;
    t_in               i_in_data     = '0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out              o_out_data;
    logic              i_out_stall   = 1'b0;

    rgb_box_downscale_frame_diff_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_stall  (i_out_stall)
    );

    // shadow of the block state
    logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    int unsigned      band_acc [BANDS][3];
    int unsigned      pos_col    = 0;
    int unsigned      pos_row    = 0;
    longint unsigned  diff_acc   = 0;

    t_out pending_results[$];
    int   error_count = 0;
    int   idle_pct    = 0;
    int   stall_pct   = 0;

    typedef struct {
        bit               cfg;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        t_in              px;
        int               reps;
        bit               typed;
        logic [7:0]       tf;
        logic [7:0]       tm;
        logic [7:0]       tt;
        logic [DIFF_W-1:0] td;
    } t_plan_row;

    t_plan_row plan [15] = '{
        '{0, 0, 0, {8'h01, 8'h02, 8'h03, 8'hFE, 8'hFD, 8'hFC}, 2, 0, 0, 0, 0, 0},
        // shrink below the current column
        '{1, 2, 1, '0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, {8'h40, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45}, 1, 0, 0, 0, 0, 0},
        '{1, 4, 4, '0, 0, 0, 0, 0, 0, 0},
        // one whole block, byte swap visible in the thumbnail
        '{0, 0, 0, {8'h00, 8'h80, 8'hFF, 8'h00, 8'h00, 8'h00}, 16, 1,
          8'hFF, 8'h80, 8'h00, 40'd1302544},
        '{1, 1, 1, '0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, {8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1, 1, 0, 0, 0, 40'd195075},
        '{0, 0, 0, {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1, 1, 0, 0, 0, 40'd195075},
        '{0, 0, 0, {8'h12, 8'h34, 8'h56, 8'h56, 8'h34, 8'h12}, 1, 1, 0, 0, 0, 40'd0},
        // sizes below and above range
        '{1, 0, 0, '0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, {8'hA5, 8'h5A, 8'h3C, 8'h0F, 8'hF0, 8'h81}, 1, 0, 0, 0, 0, 0},
        '{1, 11'h7FF, 11'h7FF, '0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, {8'hC3, 8'h3C, 8'h99, 8'h66, 8'hE7, 8'h18}, 3, 0, 0, 0, 0, 0},
        '{1, 2, 2, '0, 0, 0, 0, 0, 0, 0},
        '{0, 0, 0, {8'h7F, 8'h80, 8'h01, 8'hFE, 8'h00, 8'hFF}, 2, 0, 0, 0, 0, 0}
    };

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #12000000;
        $display("[rgb_box_downscale_frame_diff_core] ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic int unsigned eff_size(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint unsigned sq_gap(input int unsigned a, input int unsigned b);
        longint unsigned d;
        d = (a >= b) ? (a - b) : (b - a);
        return d * d;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic predict_pixel(input t_in px, input bit typed, input t_out fixed);
        int unsigned w;
        int unsigned h;
        int unsigned bc;
        int unsigned br;
        int unsigned ch[3];
        bit          line_end;
        bit          frame_end;
        t_out        res;
        t_out        found[$];
        w = eff_size(width_reg, MAX_WIDTH_DEF);
        h = eff_size(height_reg, MAX_HEIGHT);
        ch[0] = px.cap_third_byte;
        ch[1] = px.cap_middle_byte;
        ch[2] = px.cap_first_byte;
        bc = pos_col / BLOCK_SIZE_DEF;
        br = pos_row / BLOCK_SIZE_DEF;
        line_end  = (pos_col + 1 >= w);
        frame_end = line_end && (pos_row + 1 >= h);

        diff_acc += sq_gap(px.ref_first_byte, ch[0]) + sq_gap(px.ref_middle_byte, ch[1])
                  + sq_gap(px.ref_third_byte, ch[2]);
        if (diff_acc > 64'hFF_FFFF_FFFF) diff_acc = 64'hFF_FFFF_FFFF;

        if (bc < w / BLOCK_SIZE_DEF && br < h / BLOCK_SIZE_DEF && bc < BANDS) begin
            for (int c = 0; c < 3; c++) band_acc[bc][c] += ch[c];
            if (pos_col % BLOCK_SIZE_DEF == BLOCK_SIZE_DEF - 1 &&
                pos_row % BLOCK_SIZE_DEF == BLOCK_SIZE_DEF - 1) begin
                res = '0;
                res.result_kind  = KIND_THUMB;
                res.thumb_first  = 8'(band_acc[bc][0] / AREA);
                res.thumb_middle = 8'(band_acc[bc][1] / AREA);
                res.thumb_third  = 8'(band_acc[bc][2] / AREA);
                found.push_back(res);
                for (int c = 0; c < 3; c++) band_acc[bc][c] = 0;
            end
        end

        if (frame_end) begin
            res = '0;
            res.result_kind      = KIND_DIFF;
            res.frame_difference = diff_acc[DIFF_W-1:0];
            found.push_back(res);
            diff_acc = 0;
            foreach (band_acc[b, c]) band_acc[b][c] = 0;
            pos_col = 0;
            pos_row = 0;
        end else if (line_end) begin
            pos_col = 0;
            pos_row++;
        end else begin
            pos_col++;
        end

        foreach (found[i]) begin
            res = found[i];
            res.last_of_run = (i == found.size() - 1);
            if (typed && res.result_kind == KIND_THUMB) begin
                res.thumb_first  = fixed.thumb_first;
                res.thumb_middle = fixed.thumb_middle;
                res.thumb_third  = fixed.thumb_third;
            end else if (typed) begin
                res.frame_difference = fixed.frame_difference;
            end
            pending_results.push_back(res);
        end
    endtask

    // entered and left at a falling edge
    task automatic send_pixel(input t_in px, input bit typed, input t_out fixed);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= px;
        do @(posedge i_clk); while (o_in_stall);
        predict_pixel(px, typed, fixed);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_index   <= REG_FRAME_WIDTH;
        i_cfg_wr_data <= w;
        width_reg = w;
        @(negedge i_clk);
        i_cfg_index   <= REG_FRAME_HEIGHT;
        i_cfg_wr_data <= h;
        height_reg = h;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none, actual %h", $time, o_out_data);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("result_kind", want.result_kind, o_out_data.result_kind);
                check_field("thumb_first", want.thumb_first, o_out_data.thumb_first);
                check_field("thumb_middle", want.thumb_middle, o_out_data.thumb_middle);
                check_field("thumb_third", want.thumb_third, o_out_data.thumb_third);
                check_field("frame_difference", want.frame_difference,
                            o_out_data.frame_difference);
                check_field("last_of_run", want.last_of_run, o_out_data.last_of_run);
            end
        end
    end

    initial begin
        t_out             fixed;
        t_in              px;
        logic [CFG_W-1:0] w;
        logic [CFG_W-1:0] h;
        int               count;
        int               frame_px;
        int               rand_items;
        int               phase;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].cfg) begin
                wait_drained();
                write_size(plan[i].w, plan[i].h);
            end else begin
                fixed = '0;
                fixed.thumb_first      = plan[i].tf;
                fixed.thumb_middle     = plan[i].tm;
                fixed.thumb_third      = plan[i].tt;
                fixed.frame_difference = plan[i].td;
                repeat (plan[i].reps) send_pixel(plan[i].px, plan[i].typed, fixed);
            end
        end

        rand_items = 0;
        phase      = 0;
        while (rand_items < RAND_ITEMS || phase < 8) begin
            case ($urandom_range(7))
                0: begin
                    w = CFG_W'($urandom_range(3));
                    h = CFG_W'($urandom_range(3));
                end
                1: begin
                    w = CFG_W'($urandom_range(4, 24));
                    h = CFG_W'($urandom_range(1, 3));
                end
                default: begin
                    w = CFG_W'($urandom_range(4, 24));
                    h = CFG_W'($urandom_range(4, 12));
                end
            endcase
            wait_drained();
            write_size(w, h);
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 34; stall_pct = 34; end
            endcase

            frame_px = eff_size(w, MAX_WIDTH_DEF) * eff_size(h, MAX_HEIGHT);
            count = frame_px * $urandom_range(1, 2);
            // stop mid-frame now and then so the next size lands inside a frame
            if (frame_px > 1 && $urandom_range(3) == 0)
                count += $urandom_range(1, frame_px - 1);
            rand_items += count;
            repeat (count) begin
                px = {rand_byte(), rand_byte(), rand_byte(),
                      rand_byte(), rand_byte(), rand_byte()};
                send_pixel(px, 1'b0, '0);
            end
            phase++;
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (error_count == 0)
            $display("[rgb_box_downscale_frame_diff_core] OK");
        else
            $display("[rgb_box_downscale_frame_diff_core] ERROR");
        $finish;
    end

endmodule
